// ===== hdl/ecst_pkg.sv =====
// Shared types, codes and constants for the event counter semaphore table.
// No dependencies; the tag scan, count unit and top-level files in hdl/ import this package.
`default_nettype none

package ecst_pkg;

  localparam int SLOTS_DEFAULT = 32;
  localparam int HANDLE_W      = 10;
  localparam int VALUE_W       = 64;
  localparam int BLEN_W        = 12;
  localparam int STATUS_W      = 3;

  // request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_CLOSE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_WRITE  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RETRY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd4;

  localparam logic [VALUE_W-1:0] COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [VALUE_W-1:0] VALUE_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [BLEN_W-1:0]  MIN_BLEN  = 12'd8;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] handle;
    logic [VALUE_W-1:0]  value;
    logic                semaphore_mode;
    logic                nonblocking;
    logic [BLEN_W-1:0]   buffer_length;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic                readable;
  } rsp_t;

  // one counter entry with its mode flags
  typedef struct packed {
    logic               nonblock;
    logic               semaphore;
    logic [VALUE_W-1:0] count;
  } slot_word_t;

  // tag scan results
  typedef struct packed {
    logic done;
    logic hit;
    logic free_ok;
  } scan_status_t;

  // slot allocation commands to the tag store
  typedef struct packed {
    logic set;
    logic clear;
  } slot_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/ecst_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is a parameter; used with ecst_pkg request and response types.
`default_nettype none

interface ecst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ecst_tag_scan.sv =====
// Handle tag store with per-slot valid bits and a one-slot-per-cycle scanner.
// Depends on ecst_pkg.
`default_nettype none

module ecst_tag_scan #(
  parameter int SLOTS = ecst_pkg::SLOTS_DEFAULT,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ecst_pkg::HANDLE_W-1:0] handle,
  input  ecst_pkg::slot_cmd_t           cmd,
  input  logic [IW-1:0]                 cmd_idx,
  output ecst_pkg::scan_status_t        status,
  output logic [IW-1:0]                 hit_idx,
  output logic [IW-1:0]                 free_idx
);
  import ecst_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic [HANDLE_W-1:0] tag_mem [SLOTS];
  logic [HANDLE_W-1:0] tag_q;
  logic [SLOTS-1:0]    slot_valid;
  logic                issue;
  logic [IW-1:0]       scan_idx;
  logic                cmp_v;
  logic [IW-1:0]       cmp_idx;
  logic                match;
  logic                empty;

  // tag memory: write on allocation, registered read at the scan address
  always_ff @(posedge clk) begin
    if (cmd.set) begin
      tag_mem[cmd_idx] <= handle;
    end
    tag_q <= tag_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (cmd.set) begin
        slot_valid[cmd_idx] <= 1'b1;
      end
      if (cmd.clear) begin
        slot_valid[cmd_idx] <= 1'b0;
      end
    end
  end

  // address sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= issue;
      if (start) begin
        issue <= 1'b1;
      end else if (issue && scan_idx == LAST) begin
        issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      scan_idx <= '0;
    end else if (issue && scan_idx != LAST) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_idx <= scan_idx;
  end

  // shared tag comparator, one slot per cycle
  assign match = cmp_v && slot_valid[cmp_idx] && (tag_q == handle);
  assign empty = cmp_v && !slot_valid[cmp_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= cmp_v && (cmp_idx == LAST);
      if (start) begin
        status.hit     <= 1'b0;
        status.free_ok <= 1'b0;
      end else begin
        if (match) begin
          status.hit <= 1'b1;
        end
        if (empty) begin
          status.free_ok <= 1'b1;
        end
      end
    end
  end

  // keep the lowest matching and lowest free slot
  always_ff @(posedge clk) begin
    if (match && !status.hit) begin
      hit_idx <= cmp_idx;
    end
    if (empty && !status.free_ok) begin
      free_idx <= cmp_idx;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ecst_count_unit.sv =====
// Counter store (count plus mode flags per slot) and the shared 65-bit adder.
// Depends on ecst_pkg.
`default_nettype none

module ecst_count_unit #(
  parameter int SLOTS = ecst_pkg::SLOTS_DEFAULT,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                         clk,
  input  logic [IW-1:0]                rd_idx,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_idx,
  input  ecst_pkg::slot_word_t         wr_word,
  input  logic [ecst_pkg::VALUE_W-1:0] addend,
  output ecst_pkg::slot_word_t         rd_word,
  output logic [ecst_pkg::VALUE_W:0]   sum
);
  import ecst_pkg::*;

  slot_word_t count_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[wr_idx] <= wr_word;
    end
    rd_word <= count_mem[rd_idx];
  end

  // add for writes, add all-ones (decrement) for semaphore reads
  assign sum = {1'b0, rd_word.count} + {1'b0, addend};

endmodule

`default_nettype wire

// ===== hdl/event_counter_semaphore_table.sv =====
// Event counter semaphore table: handle-tagged 64-bit counters, one request per transaction.
// A new request is taken only in IDLE, once the previous one has passed SCAN, FETCH and EXEC
// and its response has been loaded; the tag scan compares one slot per cycle.
// Reset (rst, synchronous) clears all slot valid bits, the sequencer and response valid.
// Depends on ecst_pkg, ecst_stream_if, ecst_tag_scan and ecst_count_unit.
`default_nettype none

module event_counter_semaphore_table #(
  parameter int SLOTS = ecst_pkg::SLOTS_DEFAULT,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input logic          clk,
  input logic          rst,
  ecst_stream_if.sink   req,
  ecst_stream_if.source rsp
);
  import ecst_pkg::*;

  // Sequence per request:
  //   IDLE  - take a request transaction, latch it, start the tag scan
  //   SCAN  - walk every slot, recording the lowest match and lowest free slot
  //   FETCH - read the matched slot's counter word
  //   EXEC  - decide status, update the stores, load the response register;
  //           hold here while a previous response is still waiting

  state_t       state;
  state_t       state_next;
  req_t         req_q;
  scan_status_t scan_st;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  slot_cmd_t    cmd;
  logic [IW-1:0] cmd_idx;
  slot_word_t   rd_word;
  slot_word_t   cnt_wd;
  logic         cnt_we;
  logic [IW-1:0] cnt_widx;
  logic [VALUE_W-1:0] addend;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W-1:0] new_cnt;
  logic         over;
  logic         load;
  logic         accept;
  rsp_t         rsp_d;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req.data;
    end
  end

  ecst_tag_scan #(.SLOTS(SLOTS)) u_tag_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .handle   (req_q.handle),
    .cmd      (cmd),
    .cmd_idx  (cmd_idx),
    .status   (scan_st),
    .hit_idx  (hit_idx),
    .free_idx (free_idx)
  );

  // writes add the request value; semaphore reads add all-ones to decrement
  assign addend = (req_q.req_type == REQ_WRITE) ? req_q.value : VALUE_ALL;

  ecst_count_unit #(.SLOTS(SLOTS)) u_count_unit (
    .clk     (clk),
    .rd_idx  (hit_idx),
    .wr_en   (cnt_we),
    .wr_idx  (cnt_widx),
    .wr_word (cnt_wd),
    .addend  (addend),
    .rd_word (rd_word),
    .sum     (sum)
  );

  // a sum past all-ones minus one overflows the counter
  assign over = (sum >= {1'b0, VALUE_ALL});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (scan_st.done) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // request decision; store writes qualify on load so they fire once
  always_comb begin
    cmd       = '0;
    cmd_idx   = hit_idx;
    cnt_we    = 1'b0;
    cnt_widx  = hit_idx;
    new_cnt   = rd_word.count;
    cnt_wd    = rd_word;
    rsp_d     = '0;
    rsp_d.status = ST_OK;
    unique case (req_q.req_type)
      REQ_CREATE: begin
        if (scan_st.hit) begin
          // handle already in use
          rsp_d.status   = ST_INVALID;
          rsp_d.readable = (new_cnt != '0);
        end else if (!scan_st.free_ok) begin
          rsp_d.status = ST_NOSLOT;
        end else begin
          cmd.set   = load;
          cmd_idx   = free_idx;
          cnt_we    = load;
          cnt_widx  = free_idx;
          cnt_wd.nonblock  = req_q.nonblocking;
          cnt_wd.semaphore = req_q.semaphore_mode;
          cnt_wd.count     = {32'd0, req_q.value[31:0]};
          rsp_d.readable   = (req_q.value[31:0] != 32'd0);
        end
      end
      REQ_CLOSE: begin
        if (!scan_st.hit) begin
          rsp_d.status = ST_UNKNOWN;
        end else begin
          cmd.clear = load;
        end
      end
      REQ_READ, REQ_WRITE: begin
        if (req_q.buffer_length < MIN_BLEN) begin
          // short buffer wins over the lookup, counter left as is
          rsp_d.status   = ST_INVALID;
          rsp_d.readable = scan_st.hit && (new_cnt != '0);
        end else if (!scan_st.hit) begin
          rsp_d.status = ST_UNKNOWN;
        end else begin
          if (req_q.req_type == REQ_READ) begin
            if (rd_word.count == '0) begin
              rsp_d.status = ST_RETRY;
            end else if (rd_word.semaphore) begin
              rsp_d.read_value = {{(VALUE_W-1){1'b0}}, 1'b1};
              new_cnt          = sum[VALUE_W-1:0];
            end else begin
              rsp_d.read_value = rd_word.count;
              new_cnt          = '0;
            end
          end else begin
            if (req_q.value == VALUE_ALL) begin
              rsp_d.status = ST_INVALID;
            end else if (over) begin
              if (rd_word.nonblock) begin
                rsp_d.status = ST_RETRY;
              end else begin
                new_cnt = COUNT_MAX;
              end
            end else begin
              new_cnt = sum[VALUE_W-1:0];
            end
          end
          cnt_we         = load;
          cnt_wd.count   = new_cnt;
          rsp_d.readable = (new_cnt != '0);
        end
      end
      default: rsp_d.status = ST_INVALID;
    endcase
  end

  // response register: parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data <= rsp_d;
    end
  end

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_st.done |-> state == S_SCAN)
    else $error("scan finished outside the scan phase");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_EXEC)
    else $error("response raised without an execute step");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    cmd.set |-> scan_st.free_ok && !scan_st.hit && !cmd.clear)
    else $error("slot allocated without a free slot or over a live handle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.data.status <= ST_NOSLOT)
    else $error("response status out of range");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.read_value != '0 |-> rsp.data.status == ST_OK)
    else $error("read value returned with a failing status");

endmodule

`default_nettype wire
